/* hdl/ghi_pkg.sv */
`default_nettype none

package ghi_pkg;

  // Shared iteration counter and serial unit widths
  localparam int CNT_W     = 6;
  localparam int MUL_ACC_W = 56;
  localparam int MUL_MPR_W = 25;
  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 44;

  // Start request handed to a serial unit
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] count;
  } unit_req_t;

  // Configuration register indexes
  localparam logic [1:0] REG_GYRO_BIAS   = 2'd0;
  localparam logic [1:0] REG_ACCEL_LIMIT = 2'd1;
  localparam logic [1:0] REG_RATE_LIMIT  = 2'd2;

  // Fixed-point constants
  localparam logic [30:0] PI_Q29       = 31'd1686629713;
  localparam logic [30:0] TWO_PI_Q28   = 31'd1686629713;
  localparam logic [30:0] PI_Q28_FLOOR = 31'd843314856;
  localparam logic [22:0] RATE_DIVISOR = 23'd5760000;
  localparam logic [21:0] RATE_HALF    = 22'd2880000;
  localparam logic [19:0] MICRO        = 20'd1000000;
  localparam logic [18:0] MICRO_HALF   = 19'd500000;

  // Iteration counts per serial step
  localparam logic [CNT_W-1:0] CNT_CORR_MUL  = 6'd25;
  localparam logic [CNT_W-1:0] CNT_RATE_DIV  = 6'd55;
  localparam logic [CNT_W-1:0] CNT_ACC_MUL   = 6'd20;
  localparam logic [CNT_W-1:0] CNT_ACC_DIV   = 6'd53;
  localparam logic [CNT_W-1:0] CNT_DT_DIV    = 6'd32;
  localparam logic [CNT_W-1:0] CNT_REM_MUL   = 6'd20;
  localparam logic [CNT_W-1:0] CNT_REM_DIV   = 6'd55;
  localparam logic [CNT_W-1:0] CNT_WHOLE_MUL = 6'd13;
  localparam logic [CNT_W-1:0] CNT_WRAP_DIV  = 6'd49;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CORR_MUL,
    S_RATE_DIV,
    S_ACC_MUL,
    S_ACC_DIV,
    S_DT_DIV,
    S_REM_MUL,
    S_REM_DIV,
    S_WHOLE_MUL,
    S_SUM,
    S_WRAP_DIV,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

/* hdl/ghi_serial_mul.sv */
`default_nettype none

// Shift-add multiplier: one multiplier bit per cycle, accumulator preloaded
module ghi_serial_mul (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ghi_pkg::unit_req_t             req,
  input  wire logic [ghi_pkg::MUL_ACC_W-1:0]  mcand,
  input  wire logic [ghi_pkg::MUL_MPR_W-1:0]  mplier,
  input  wire logic [ghi_pkg::MUL_ACC_W-1:0]  acc_init,
  output logic                                done,
  output logic [ghi_pkg::MUL_ACC_W-1:0]       product
);

  logic                          busy;
  logic [ghi_pkg::CNT_W-1:0]     cnt;
  logic [ghi_pkg::MUL_ACC_W-1:0] mcand_reg;
  logic [ghi_pkg::MUL_MPR_W-1:0] mplier_reg;
  logic [ghi_pkg::MUL_ACC_W-1:0] acc;
  logic [ghi_pkg::MUL_ACC_W-1:0] addend;

  assign addend  = mplier_reg[0] ? mcand_reg : '0;
  assign product = acc;

  // Track iterations and flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
      end else if (busy) begin
        cnt <= cnt - ghi_pkg::CNT_W'(1);
        if (cnt == ghi_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Load operands, then add and shift one bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand_reg  <= mcand;
      mplier_reg <= mplier;
      acc        <= acc_init;
    end else if (busy) begin
      acc        <= acc + addend;
      mcand_reg  <= {mcand_reg[ghi_pkg::MUL_ACC_W-2:0], 1'b0};
      mplier_reg <= {1'b0, mplier_reg[ghi_pkg::MUL_MPR_W-1:1]};
    end
  end

endmodule

`default_nettype wire

/* hdl/ghi_serial_div.sv */
`default_nettype none

// Restoring divider: one quotient bit per cycle, numerator left-justified
module ghi_serial_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire ghi_pkg::unit_req_t             req,
  input  wire logic [ghi_pkg::DIV_NUM_W-1:0]  num,
  input  wire logic [ghi_pkg::DIV_DEN_W-1:0]  den,
  output logic                                done,
  output logic [ghi_pkg::DIV_NUM_W-1:0]       quot,
  output logic [ghi_pkg::DIV_DEN_W-1:0]       rem
);

  logic                          busy;
  logic [ghi_pkg::CNT_W-1:0]     cnt;
  logic [ghi_pkg::DIV_NUM_W-1:0] shift_reg;
  logic [ghi_pkg::DIV_DEN_W-1:0] rem_reg;
  logic [ghi_pkg::DIV_DEN_W-1:0] den_reg;
  logic [ghi_pkg::DIV_DEN_W+1:0] trial;
  logic                          fits;

  assign trial = {1'b0, rem_reg, shift_reg[ghi_pkg::DIV_NUM_W-1]} - {2'b00, den_reg};
  assign fits  = !trial[ghi_pkg::DIV_DEN_W+1];
  assign quot  = shift_reg;
  assign rem   = rem_reg;

  // Track iterations and flag the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
      end else if (busy) begin
        cnt <= cnt - ghi_pkg::CNT_W'(1);
        if (cnt == ghi_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift in one numerator bit, subtract when the divisor fits
  always_ff @(posedge clk) begin
    if (req.start) begin
      shift_reg <= num;
      rem_reg   <= '0;
      den_reg   <= den;
    end else if (busy) begin
      shift_reg <= {shift_reg[ghi_pkg::DIV_NUM_W-2:0], fits};
      if (fits) begin
        rem_reg <= trial[ghi_pkg::DIV_DEN_W-1:0];
      end else begin
        rem_reg <= {rem_reg[ghi_pkg::DIV_DEN_W-2:0], shift_reg[ghi_pkg::DIV_NUM_W-1]};
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/gyro_heading_integrator_core.sv */
`default_nettype none

// Gyro heading integrator.
// Input channel (in_valid/in_ready) carries one transaction per gyro sample:
// operation (0 sample, 1 clear headings and time reference), gyro_z_mdps and
// time_us. Output channel (out_valid/out_ready) returns one result transaction
// per input: wrapped and unwrapped heading, corrected rate, held acceleration
// and the emergency flag. Registers are written through cfg_we/cfg_index/
// cfg_data; the user must write them only while the block is idle, which the
// block itself does not enforce. A sample runs through one shared shift-add
// multiplier and one shared restoring divider, one bit per cycle; the
// acceleration is recomputed only when the elapsed time exceeds one
// microsecond. A clear transaction goes straight to the finish state, which
// loads the result register. One transaction is in work at a time; in_ready
// is high only between transactions, so the next transaction is taken only
// once the sequencer is back in the idle state.
// The result register holds its transaction while out_ready is low; the next
// input is accepted meanwhile, and its result waits until the register frees.
// Synchronous reset clears headings, time reference, rate and acceleration
// history, and loads the register defaults.
module gyro_heading_integrator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [17:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [23:0] gyro_z_mdps,
  input  wire logic [31:0] time_us,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [30:0]      angle,
  output logic [47:0]      unwrapped_angle,
  output logic [31:0]      rate,
  output logic [31:0]      angular_accel,
  output logic             emergency
);

  ghi_pkg::state_t state, state_next;
  logic            kick;

  // Configuration
  logic [17:0] gyro_bias_mdps;
  logic [15:0] accel_limit;
  logic [6:0]  rate_limit;

  // Integrator state and working registers
  logic [31:0] last_time;
  logic        time_valid;
  logic [31:0] prev_rate;
  logic [31:0] accel_hold;
  logic [30:0] heading;
  logic [47:0] total_heading;
  logic [31:0] dt;
  logic [24:0] corr;
  logic [31:0] rate_cur;
  logic        diff_neg;
  logic [12:0] dt_q;
  logic [19:0] dt_r;
  logic [35:0] frac;
  logic [48:0] inc;
  logic [49:0] sum_val;

  // Combinational helpers
  logic [24:0] sample_corr;
  logic [24:0] corr_mag;
  logic [32:0] rate_diff;
  logic [32:0] diff_mag;
  logic [31:0] rate_mag;
  logic [48:0] sum_mag;
  logic [30:0] wrap_rem;
  logic [30:0] heading_wrapped;
  logic [31:0] accel_mag;
  logic [31:0] prev_mag;
  logic        emergency_next;
  logic        out_load;
  logic        accept;

  // Serial unit ports
  ghi_pkg::unit_req_t              mul_req, div_req;
  logic [ghi_pkg::MUL_ACC_W-1:0]   mul_mcand, mul_acc_init, mul_product;
  logic [ghi_pkg::MUL_MPR_W-1:0]   mul_mplier;
  logic                            mul_done;
  logic [ghi_pkg::DIV_NUM_W-1:0]   div_num, div_quot;
  logic [ghi_pkg::DIV_DEN_W-1:0]   div_den, div_rem;
  logic                            div_done;

  function automatic logic [31:0] sat_mag(input logic [55:0] mag, input logic neg);
    logic [31:0] res;
    if (neg) begin
      res = (mag > 56'h80000000) ? 32'h80000000 : (~mag[31:0] + 32'd1);
    end else begin
      res = (mag > 56'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
    end
    return res;
  endfunction

  ghi_serial_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .req      (mul_req),
    .mcand    (mul_mcand),
    .mplier   (mul_mplier),
    .acc_init (mul_acc_init),
    .done     (mul_done),
    .product  (mul_product)
  );

  ghi_serial_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot),
    .rem  (div_rem)
  );

  // Magnitudes and differences feeding the serial units
  assign sample_corr = {gyro_z_mdps[23], gyro_z_mdps} -
                       {{7{gyro_bias_mdps[17]}}, gyro_bias_mdps};
  assign corr_mag    = corr[24] ? (~corr + 25'd1) : corr;
  assign rate_diff   = {rate_cur[31], rate_cur} - {prev_rate[31], prev_rate};
  assign diff_mag    = rate_diff[32] ? (~rate_diff + 33'd1) : rate_diff;
  assign rate_mag    = rate_cur[31] ? (~rate_cur + 32'd1) : rate_cur;
  assign sum_mag     = sum_val[49] ? (~sum_val[48:0] + 49'd1) : sum_val[48:0];
  assign accel_mag   = accel_hold[31] ? (~accel_hold + 32'd1) : accel_hold;
  assign prev_mag    = prev_rate[31] ? (~prev_rate + 32'd1) : prev_rate;
  assign accept      = in_valid && in_ready;

  // Fold the remainder of the heading into the half-open turn around zero
  assign wrap_rem = div_rem[30:0];
  always_comb begin
    if (!sum_val[49]) begin
      heading_wrapped = (wrap_rem > ghi_pkg::PI_Q28_FLOOR) ?
                        (wrap_rem - ghi_pkg::TWO_PI_Q28) : wrap_rem;
    end else if (wrap_rem == '0) begin
      heading_wrapped = '0;
    end else if (wrap_rem <= ghi_pkg::PI_Q28_FLOOR) begin
      heading_wrapped = ~wrap_rem + 31'd1;
    end else begin
      heading_wrapped = ghi_pkg::TWO_PI_Q28 - wrap_rem;
    end
  end

  assign emergency_next = (accel_mag > {4'b0000, accel_limit, 12'h000}) ||
                          (prev_mag > {1'b0, rate_limit, 24'h000000});

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ghi_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = operation ? ghi_pkg::S_FINISH : ghi_pkg::S_CORR_MUL;
        end
      end
      ghi_pkg::S_CORR_MUL: begin
        if (mul_done) state_next = ghi_pkg::S_RATE_DIV;
      end
      ghi_pkg::S_RATE_DIV: begin
        if (div_done) begin
          state_next = (dt > 32'd1) ? ghi_pkg::S_ACC_MUL : ghi_pkg::S_DT_DIV;
        end
      end
      ghi_pkg::S_ACC_MUL: begin
        if (mul_done) state_next = ghi_pkg::S_ACC_DIV;
      end
      ghi_pkg::S_ACC_DIV: begin
        if (div_done) state_next = ghi_pkg::S_DT_DIV;
      end
      ghi_pkg::S_DT_DIV: begin
        if (div_done) state_next = ghi_pkg::S_REM_MUL;
      end
      ghi_pkg::S_REM_MUL: begin
        if (mul_done) state_next = ghi_pkg::S_REM_DIV;
      end
      ghi_pkg::S_REM_DIV: begin
        if (div_done) state_next = ghi_pkg::S_WHOLE_MUL;
      end
      ghi_pkg::S_WHOLE_MUL: begin
        if (mul_done) state_next = ghi_pkg::S_SUM;
      end
      ghi_pkg::S_SUM: begin
        state_next = ghi_pkg::S_WRAP_DIV;
      end
      ghi_pkg::S_WRAP_DIV: begin
        if (div_done) state_next = ghi_pkg::S_FINISH;
      end
      ghi_pkg::S_FINISH: begin
        if (!out_valid || out_ready) state_next = ghi_pkg::S_IDLE;
      end
      default: state_next = ghi_pkg::S_IDLE;
    endcase
  end

  // Outputs: handshake, unit starts and operand selection
  always_comb begin
    in_ready      = 1'b0;
    out_load      = 1'b0;
    mul_req.start = 1'b0;
    mul_req.count = '0;
    div_req.start = 1'b0;
    div_req.count = '0;
    mul_mcand     = '0;
    mul_mplier    = '0;
    mul_acc_init  = '0;
    div_num       = '0;
    div_den       = '0;
    unique case (state)
      ghi_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      ghi_pkg::S_CORR_MUL: begin
        mul_req.start = kick;
        mul_req.count = ghi_pkg::CNT_CORR_MUL;
        mul_mcand     = {25'd0, ghi_pkg::PI_Q29};
        mul_mplier    = corr_mag;
        mul_acc_init  = {34'd0, ghi_pkg::RATE_HALF};
      end
      ghi_pkg::S_RATE_DIV: begin
        div_req.start = kick;
        div_req.count = ghi_pkg::CNT_RATE_DIV;
        div_num       = {mul_product[54:0], 1'b0};
        div_den       = {21'd0, ghi_pkg::RATE_DIVISOR};
      end
      ghi_pkg::S_ACC_MUL: begin
        mul_req.start = kick;
        mul_req.count = ghi_pkg::CNT_ACC_MUL;
        mul_mcand     = {23'd0, diff_mag};
        mul_mplier    = {5'd0, ghi_pkg::MICRO};
        mul_acc_init  = {13'd0, dt, 11'd0};
      end
      ghi_pkg::S_ACC_DIV: begin
        div_req.start = kick;
        div_req.count = ghi_pkg::CNT_ACC_DIV;
        div_num       = {mul_product[52:0], 3'd0};
        div_den       = {dt, 12'd0};
      end
      ghi_pkg::S_DT_DIV: begin
        div_req.start = kick;
        div_req.count = ghi_pkg::CNT_DT_DIV;
        div_num       = {dt, 24'd0};
        div_den       = {24'd0, ghi_pkg::MICRO};
      end
      ghi_pkg::S_REM_MUL: begin
        mul_req.start = kick;
        mul_req.count = ghi_pkg::CNT_REM_MUL;
        mul_mcand     = {20'd0, rate_mag, 4'd0};
        mul_mplier    = {5'd0, dt_r};
        mul_acc_init  = {37'd0, ghi_pkg::MICRO_HALF};
      end
      ghi_pkg::S_REM_DIV: begin
        div_req.start = kick;
        div_req.count = ghi_pkg::CNT_REM_DIV;
        div_num       = {mul_product[54:0], 1'b0};
        div_den       = {24'd0, ghi_pkg::MICRO};
      end
      ghi_pkg::S_WHOLE_MUL: begin
        mul_req.start = kick;
        mul_req.count = ghi_pkg::CNT_WHOLE_MUL;
        mul_mcand     = {20'd0, rate_mag, 4'd0};
        mul_mplier    = {12'd0, dt_q};
        mul_acc_init  = {20'd0, frac};
      end
      ghi_pkg::S_SUM: begin
      end
      ghi_pkg::S_WRAP_DIV: begin
        div_req.start = kick;
        div_req.count = ghi_pkg::CNT_WRAP_DIV;
        div_num       = {sum_mag, 7'd0};
        div_den       = {13'd0, ghi_pkg::TWO_PI_Q28};
      end
      ghi_pkg::S_FINISH: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  // State register and start strobe on every state entry
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ghi_pkg::S_IDLE;
      kick  <= 1'b0;
    end else begin
      state <= state_next;
      kick  <= (state_next != state);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_bias_mdps <= 18'h3FEDE;
      accel_limit    <= 16'd6000;
      rate_limit     <= 7'd35;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ghi_pkg::REG_GYRO_BIAS:   gyro_bias_mdps <= cfg_data;
        ghi_pkg::REG_ACCEL_LIMIT: accel_limit    <= cfg_data[15:0];
        ghi_pkg::REG_RATE_LIMIT:  rate_limit     <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Integrator state: time reference, rate and acceleration history, headings
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time     <= '0;
      time_valid    <= 1'b0;
      prev_rate     <= '0;
      accel_hold    <= '0;
      heading       <= '0;
      total_heading <= '0;
    end else begin
      if (accept) begin
        if (operation) begin
          time_valid    <= 1'b0;
          heading       <= '0;
          total_heading <= '0;
        end else begin
          last_time  <= time_us;
          time_valid <= 1'b1;
        end
      end
      if (state == ghi_pkg::S_ACC_DIV && div_done) begin
        accel_hold <= sat_mag(div_quot, diff_neg);
      end
      if (state == ghi_pkg::S_DT_DIV && kick) begin
        prev_rate <= rate_cur;
      end
      if (state == ghi_pkg::S_SUM) begin
        total_heading <= total_heading + inc[47:0];
      end
      if (state == ghi_pkg::S_WRAP_DIV && div_done) begin
        heading <= heading_wrapped;
      end
    end
  end

  // Working registers of the sample in flight
  always_ff @(posedge clk) begin
    if (accept && !operation) begin
      dt   <= time_valid ? (time_us - last_time) : '0;
      corr <= sample_corr;
    end
    if (state == ghi_pkg::S_RATE_DIV && div_done) begin
      rate_cur <= sat_mag(div_quot, corr[24]);
    end
    if (state == ghi_pkg::S_ACC_MUL && kick) begin
      diff_neg <= rate_diff[32];
    end
    if (state == ghi_pkg::S_DT_DIV && div_done) begin
      dt_q <= div_quot[12:0];
      dt_r <= div_rem[19:0];
    end
    if (state == ghi_pkg::S_REM_DIV && div_done) begin
      frac <= div_quot[35:0];
    end
    if (state == ghi_pkg::S_WHOLE_MUL && mul_done) begin
      inc <= rate_cur[31] ? (~{1'b0, mul_product[47:0]} + 49'd1) :
                            {1'b0, mul_product[47:0]};
    end
    if (state == ghi_pkg::S_SUM) begin
      sum_val <= {{19{heading[30]}}, heading} + {inc[48], inc};
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      angle           <= heading;
      unwrapped_angle <= total_heading;
      rate            <= prev_rate;
      angular_accel   <= accel_hold;
      emergency       <= emergency_next;
    end
  end

  // Acceleration is computed only over an interval above one microsecond
  a_acc_needs_dt: assert property (@(posedge clk) disable iff (rst)
    (state == ghi_pkg::S_ACC_MUL) |-> (dt > 32'd1))
    else $error("acceleration step entered with short interval");

  // A clear transaction zeroes headings and drops the time reference
  a_clear_item: assert property (@(posedge clk) disable iff (rst)
    (accept && operation) |=> (heading == '0 && total_heading == '0 && !time_valid))
    else $error("clear transaction did not reset headings");

  // Wrapped heading stays within one half turn of zero
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    ($signed(heading) <= $signed({1'b0, ghi_pkg::PI_Q28_FLOOR})) &&
    ($signed(heading) >= -$signed({1'b0, ghi_pkg::PI_Q28_FLOOR})))
    else $error("wrapped heading out of range");

  // The shared units never finish in the same cycle
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(mul_done && div_done))
    else $error("multiplier and divider finished together");

  // A new result appears only from the finish state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ghi_pkg::S_FINISH))
    else $error("result raised outside finish state");

endmodule

`default_nettype wire
